/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* hw/rtl/aakf_pkg.sv */
// Types and constants of the adaptive angle Kalman filter
`default_nettype none
package aakf_pkg;
   localparam int ANGLE_WIDTH = 16;
   localparam int EXT_WIDTH = 42;
   localparam int CSR_INDEX_WIDTH = 8;
   localparam int CSR_DATA_WIDTH = 32;

   localparam logic [30:0] PROCESS_NOISE_RESET = 31'd196608;
   localparam logic [30:0] NOISE_GAIN_RESET = 31'd6553600;
   localparam logic [30:0] NOISE_FLOOR_RESET = 31'd38037094;
   localparam logic signed [31:0] INIT_COV_RESET = -32'sd642689;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_PROCESS_NOISE = 8'd0,
      CSR_NOISE_GAIN = 8'd1,
      CSR_NOISE_FLOOR = 8'd2,
      CSR_INIT_COV = 8'd3
   } aakf_csr_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_PRED,
      S_ABS,
      S_POW_MUL,
      S_POW_FIX,
      S_GAIN_MUL,
      S_GAIN_FIX,
      S_DEN,
      S_DIV,
      S_DIV_FIX,
      S_KV_SET,
      S_KV_MUL,
      S_KV_FIX,
      S_OM,
      S_PK_SET,
      S_PK_MUL,
      S_PK_FIX,
      S_OUT
   } aakf_state_type;
endpackage
`default_nettype wire

/* hw/rtl/aakf_channels.sv */
// Handshake channel interfaces of the adaptive angle Kalman filter
`default_nettype none
interface aakf_req_if import aakf_pkg::*; ();
   logic valid;
   logic ready;
   logic signed [ANGLE_WIDTH-1:0] angle_x;
   logic signed [ANGLE_WIDTH-1:0] angle_y;
   modport source(output valid, output angle_x, output angle_y, input ready);
   modport sink(input valid, input angle_x, input angle_y, output ready);
endinterface

interface aakf_rsp_if import aakf_pkg::*; ();
   logic valid;
   logic ready;
   logic signed [ANGLE_WIDTH-1:0] est_x;
   logic signed [ANGLE_WIDTH-1:0] est_y;
   modport source(output valid, output est_x, output est_y, input ready);
   modport sink(input valid, input est_x, input est_y, output ready);
endinterface

interface aakf_csr_if import aakf_pkg::*; ();
   logic valid;
   logic ready;
   logic [CSR_INDEX_WIDTH-1:0] index;
   logic [CSR_DATA_WIDTH-1:0] data;
   modport source(output valid, output index, output data, input ready);
   modport sink(input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* hw/rtl/adaptive_angle_kalman_filter_core.sv */
// Two-axis adaptive scalar Kalman filter core with bit-serial arithmetic
//
//   channel   dir   payload                 handshake
//   req_ch    in    angle_x, angle_y        valid/ready
//   rsp_ch    out   est_x, est_y            valid/ready
//   csr_ch    in    index, data             valid/ready, always ready
//
// Each item passes through the shared bit-serial multiplier (seven products per axis)
// and the restoring divider; a non-positive denominator skips the divide and the
// correction product. Axes run one after the other. A new item is accepted only
// in idle, after the result of the last one has entered the output register.
// Reset is synchronous, clears control state and restores register defaults.
// A stalled result sits in the output register while the next item is processed.
`default_nettype none
`include "assert_macros.svh"
module adaptive_angle_kalman_filter_core import aakf_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   aakf_req_if.sink   req_ch,
   aakf_rsp_if.source rsp_ch,
   aakf_csr_if.sink   csr_ch
);
   localparam logic signed [EXT_WIDTH-1:0] QMAX_EXT = EXT_WIDTH'(64'sh7FFFFFFF);
   localparam logic signed [EXT_WIDTH-1:0] QMIN_EXT = -EXT_WIDTH'(64'sh80000000);
   localparam logic signed [EXT_WIDTH-1:0] AMAX_EXT =
      EXT_WIDTH'((64'sd1 <<< (ANGLE_WIDTH - 1)) - 64'sd1);
   localparam logic signed [EXT_WIDTH-1:0] AMIN_EXT =
      -EXT_WIDTH'(64'sd1 <<< (ANGLE_WIDTH - 1));

   aakf_state_type state_ff, state_in;

   logic [30:0] pn_ff, gain_ff, floor_ff;
   logic signed [31:0] init_cov_ff;

   logic signed [ANGLE_WIDTH-1:0] est_ff [2];
   logic signed [ANGLE_WIDTH-1:0] est_in [2];
   logic signed [31:0] cov_ff [2];
   logic signed [31:0] cov_in [2];
   logic signed [ANGLE_WIDTH-1:0] z_ff [2];
   logic signed [ANGLE_WIDTH-1:0] z_in [2];
   logic axis_ff, axis_in, primed_ff, primed_in;

   logic signed [31:0] ppred_ff, ppred_in, v_ff, v_in, k_ff, k_in, om_ff, om_in;
   logic [31:0] pmag_ff, pmag_in, vmag_ff, vmag_in, mcand_ff, mcand_in;
   logic [30:0] a_ff, a_in, pw_ff, pw_in, r_ff, r_in;
   logic neg_ff, neg_in;
   logic [63:0] prod_ff, prod_in;
   logic [32:0] divisor_ff, divisor_in, rem_ff, rem_in;
   logic [47:0] quo_ff, quo_in;
   logic [5:0] cnt_ff, cnt_in;
   logic [1:0] pw_cnt_ff, pw_cnt_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic signed [ANGLE_WIDTH-1:0] rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;

   logic req_fire, out_free, mul_last;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_fire = req_ch.valid && req_ch.ready;
   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign mul_last = (cnt_ff == 6'd31);
   assign csr_ch.ready = 1'b1;
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.est_x = rsp_x_ff;
   assign rsp_ch.est_y = rsp_y_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (req_fire) state_in = S_PRED;
         S_PRED: state_in = S_ABS;
         S_ABS: state_in = S_POW_MUL;
         S_POW_MUL: if (mul_last) state_in = S_POW_FIX;
         S_POW_FIX: state_in = (pw_cnt_ff == 2'd3) ? S_GAIN_MUL : S_POW_MUL;
         S_GAIN_MUL: if (mul_last) state_in = S_GAIN_FIX;
         S_GAIN_FIX: state_in = S_DEN;
         S_DEN: begin
            state_in = (($signed({2'b0, r_ff}) + 33'(ppred_ff)) > 33'sd0) ? S_DIV : S_OM;
         end
         S_DIV: if (cnt_ff == 6'd47) state_in = S_DIV_FIX;
         S_DIV_FIX: state_in = S_KV_SET;
         S_KV_SET: state_in = S_KV_MUL;
         S_KV_MUL: if (mul_last) state_in = S_KV_FIX;
         S_KV_FIX: state_in = S_OM;
         S_OM: state_in = S_PK_SET;
         S_PK_SET: state_in = S_PK_MUL;
         S_PK_MUL: if (mul_last) state_in = S_PK_FIX;
         S_PK_FIX: state_in = axis_ff ? S_OUT : S_PRED;
         S_OUT: if (out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      logic signed [EXT_WIDTH-1:0] dz, vv, delta, esum;
      logic signed [32:0] pp;
      logic signed [33:0] om_full;
      logic signed [32:0] den;
      logic [32:0] mul_sum, rsum;
      logic [33:0] shifted;
      logic [34:0] trial;
      logic [47:0] hi48;
      logic [39:0] hi40;
      logic [31:0] kmag, ommag;

      est_in = est_ff;
      cov_in = cov_ff;
      z_in = z_ff;
      axis_in = axis_ff;
      primed_in = primed_ff;
      ppred_in = ppred_ff;
      v_in = v_ff;
      k_in = k_ff;
      om_in = om_ff;
      pmag_in = pmag_ff;
      vmag_in = vmag_ff;
      mcand_in = mcand_ff;
      a_in = a_ff;
      pw_in = pw_ff;
      r_in = r_ff;
      neg_in = neg_ff;
      prod_in = prod_ff;
      divisor_in = divisor_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      pw_cnt_in = pw_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_x_in = rsp_x_ff;
      rsp_y_in = rsp_y_ff;

      dz = EXT_WIDTH'(z_ff[axis_ff]) - EXT_WIDTH'(est_ff[axis_ff]);
      vv = dz <<< 8;
      pp = 33'(cov_ff[axis_ff]) + $signed({2'b0, pn_ff});
      om_full = 34'sd65536 - 34'(k_ff);
      den = $signed({2'b0, r_ff}) + 33'(ppred_ff);
      mul_sum = {1'b0, prod_ff[63:32]} + (prod_ff[0] ? {1'b0, mcand_ff} : 33'd0);
      shifted = {rem_ff, quo_ff[47]};
      trial = {1'b0, shifted} - {2'b0, divisor_ff};
      hi48 = prod_ff[63:16];
      hi40 = prod_ff[63:24];
      kmag = k_ff[31] ? 32'(-k_ff) : 32'(k_ff);
      ommag = om_ff[31] ? 32'(-om_ff) : 32'(om_ff);
      rsum = {2'b0, r_ff} + {2'b0, floor_ff};
      delta = neg_ff ? -$signed({2'b0, hi40}) : $signed({2'b0, hi40});
      esum = EXT_WIDTH'(est_ff[axis_ff]) + delta;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               z_in[0] = req_ch.angle_x;
               z_in[1] = req_ch.angle_y;
               axis_in = 1'b0;
               primed_in = 1'b1;
               if (!primed_ff) begin
                  cov_in[0] = init_cov_ff;
                  cov_in[1] = init_cov_ff;
               end
            end
         end
         S_PRED: begin
            ppred_in = (!pp[32] && pp[31]) ? 32'sh7FFFFFFF : pp[31:0];
            if (vv > QMAX_EXT) v_in = 32'sh7FFFFFFF;
            else if (vv < QMIN_EXT) v_in = 32'sh80000000;
            else v_in = vv[31:0];
         end
         S_ABS: begin
            vmag_in = v_ff[31] ? 32'(-v_ff) : 32'(v_ff);
            pmag_in = ppred_ff[31] ? 32'(-ppred_ff) : 32'(ppred_ff);
            a_in = (v_ff == 32'sh80000000) ? 31'h7FFFFFFF :
                   (v_ff[31] ? 31'(-v_ff) : v_ff[30:0]);
            mcand_in = {1'b0, a_in};
            prod_in = {32'd0, 1'b0, a_in};
            cnt_in = 6'd0;
            pw_cnt_in = 2'd0;
         end
         S_POW_MUL, S_GAIN_MUL, S_KV_MUL, S_PK_MUL: begin
            prod_in = {mul_sum, prod_ff[31:1]};
            cnt_in = cnt_ff + 6'd1;
         end
         S_POW_FIX: begin
            pw_in = (hi48 > 48'h7FFFFFFF) ? 31'h7FFFFFFF : hi48[30:0];
            pw_cnt_in = pw_cnt_ff + 2'd1;
            cnt_in = 6'd0;
            if (pw_cnt_ff == 2'd3) begin
               mcand_in = {1'b0, gain_ff};
               prod_in = {32'd0, 1'b0, pw_in};
            end else begin
               mcand_in = {1'b0, pw_in};
               prod_in = {32'd0, 1'b0, a_ff};
            end
         end
         S_GAIN_FIX: begin
            r_in = (hi48 > 48'h7FFFFFFF) ? 31'h7FFFFFFF : hi48[30:0];
            rsum = {2'b0, r_in} + {2'b0, floor_ff};
            r_in = (rsum > 33'h7FFFFFFF) ? 31'h7FFFFFFF : rsum[30:0];
         end
         S_DEN: begin
            k_in = 32'sd0;
            divisor_in = den[32:0];
            quo_in = {pmag_ff, 16'd0};
            rem_in = 33'd0;
            cnt_in = 6'd0;
            neg_in = ppred_ff[31];
         end
         S_DIV: begin
            if (!trial[34]) rem_in = trial[32:0];
            else rem_in = shifted[32:0];
            quo_in = {quo_ff[46:0], !trial[34]};
            cnt_in = cnt_ff + 6'd1;
         end
         S_DIV_FIX: begin
            if (neg_ff) k_in = (quo_ff > 48'h80000000) ? 32'sh80000000 : 32'(-quo_ff);
            else k_in = (quo_ff > 48'h7FFFFFFF) ? 32'sh7FFFFFFF : quo_ff[31:0];
         end
         S_KV_SET: begin
            mcand_in = kmag;
            prod_in = {32'd0, vmag_ff};
            neg_in = k_ff[31] ^ v_ff[31];
            cnt_in = 6'd0;
         end
         S_KV_FIX: begin
            if (esum > AMAX_EXT) est_in[axis_ff] = AMAX_EXT[ANGLE_WIDTH-1:0];
            else if (esum < AMIN_EXT) est_in[axis_ff] = AMIN_EXT[ANGLE_WIDTH-1:0];
            else est_in[axis_ff] = esum[ANGLE_WIDTH-1:0];
         end
         S_OM: begin
            om_in = (om_full > 34'sh7FFFFFFF) ? 32'sh7FFFFFFF : om_full[31:0];
         end
         S_PK_SET: begin
            mcand_in = ommag;
            prod_in = {32'd0, pmag_ff};
            neg_in = om_ff[31] ^ ppred_ff[31];
            cnt_in = 6'd0;
         end
         S_PK_FIX: begin
            if (neg_ff) cov_in[axis_ff] = (hi48 > 48'h80000000) ? 32'sh80000000 : 32'(-hi48);
            else cov_in[axis_ff] = (hi48 > 48'h7FFFFFFF) ? 32'sh7FFFFFFF : hi48[31:0];
            axis_in = 1'b1;
         end
         S_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_x_in = est_ff[0];
               rsp_y_in = est_ff[1];
            end
         end
         default: begin
            cnt_in = 6'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      z_ff <= z_in;
      axis_ff <= axis_in;
      ppred_ff <= ppred_in;
      v_ff <= v_in;
      k_ff <= k_in;
      om_ff <= om_in;
      pmag_ff <= pmag_in;
      vmag_ff <= vmag_in;
      mcand_ff <= mcand_in;
      a_ff <= a_in;
      pw_ff <= pw_in;
      r_ff <= r_in;
      neg_ff <= neg_in;
      prod_ff <= prod_in;
      divisor_ff <= divisor_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      pw_cnt_ff <= pw_cnt_in;
      rsp_x_ff <= rsp_x_in;
      rsp_y_ff <= rsp_y_in;
      if (reset) begin
         state_ff <= S_IDLE;
         primed_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         est_ff[0] <= '0;
         est_ff[1] <= '0;
         cov_ff[0] <= '0;
         cov_ff[1] <= '0;
         pn_ff <= PROCESS_NOISE_RESET;
         gain_ff <= NOISE_GAIN_RESET;
         floor_ff <= NOISE_FLOOR_RESET;
         init_cov_ff <= INIT_COV_RESET;
      end else begin
         state_ff <= state_in;
         primed_ff <= primed_in;
         rsp_valid_ff <= rsp_valid_in;
         est_ff <= est_in;
         cov_ff <= cov_in;
         if (csr_ch.valid && csr_ch.ready) begin
            case (aakf_csr_type'(csr_ch.index))
               CSR_PROCESS_NOISE: pn_ff <= csr_ch.data[30:0];
               CSR_NOISE_GAIN: gain_ff <= csr_ch.data[30:0];
               CSR_NOISE_FLOOR: floor_ff <= csr_ch.data[30:0];
               CSR_INIT_COV: init_cov_ff <= $signed(csr_ch.data);
               default: pn_ff <= pn_ff;
            endcase
         end
      end
   end

   `ASSERT_NEXT(a_accept_starts, clock, reset, req_fire, state_ff == S_PRED && primed_ff)
   `ASSERT_NEXT(a_first_axis_loops, clock, reset, state_ff == S_PK_FIX && !axis_ff,
      state_ff == S_PRED && axis_ff)
   `ASSERT_NEXT(a_result_issued, clock, reset, state_ff == S_OUT && out_free,
      rsp_valid_ff && state_ff == S_IDLE)
   `ASSERT_IMPLIES(a_mul_count, clock, reset,
      state_ff == S_POW_MUL || state_ff == S_KV_MUL, cnt_ff < 6'd32)
endmodule
`default_nettype wire
